// ----- rtl/lss_pkg.sv -----
// Shared types and constants of the Laplacian sharpen stream.
// Used by the arithmetic pipeline and the top level; depends on nothing.
package lss_pkg;

  // Fixed field and register widths, row limit and fixed-point constants
  localparam int PixW    = 16;
  localparam int SumW    = PixW + 2;
  localparam int LwW     = 12;
  localparam int LcW     = 13;
  localparam int StrW    = 13;
  localparam int RowW    = 12;
  localparam int MaxRows = 4096;
  localparam int QOne    = 4096;
  localparam int QShift  = 12;

  typedef logic [PixW-1:0] pix_t;
  typedef logic [SumW-1:0] sum_t;

  // Register indexes of the configuration port
  typedef enum logic [1:0] {
    CFG_LINE_WIDTH = 2'd0,
    CFG_LINE_COUNT = 2'd1,
    CFG_STRENGTH   = 2'd2
  } cfg_idx_e;

  // Neighborhood word handed from the window to the arithmetic pipeline
  typedef struct packed {
    pix_t center;
    sum_t sum4;
    logic last;
  } win_t;

endpackage

// ----- rtl/lss_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Read-first on a same-address write; standalone, no package.
module lss_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read old contents, then write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/lss_calc.sv -----
// Arithmetic pipeline: product stage, subtract and clamp, output register.
// Depends on lss_pkg for the window word and the fixed-point constants.
module lss_calc (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [lss_pkg::StrW-1:0]      strength_i,
  input  logic                          take_valid_i,
  input  lss_pkg::win_t                 take_win_i,
  output logic                          take_free_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output lss_pkg::pix_t                 sharp_value_o,
  output logic                          frame_last_o
);

  localparam int CoefW = lss_pkg::PixW;
  localparam int ProdAW = CoefW + lss_pkg::PixW;
  localparam int ProdBW = lss_pkg::StrW + lss_pkg::SumW;
  localparam int AccW = ProdAW + 1;

  // Stage 2: window word
  logic          s2_valid_q;
  lss_pkg::win_t s2_win_q;
  // Stage 3: products
  logic              s3_valid_q;
  logic [ProdAW-1:0] prod_a_q;
  logic [ProdBW-1:0] prod_b_q;
  logic              s3_last_q;
  // Output register
  logic          out_valid_q;
  lss_pkg::pix_t out_value_q;
  lss_pkg::pix_t out_value_d;
  logic          out_last_q;

  logic              out_free;
  logic              s3_free;
  logic              s2_free;
  logic [CoefW-1:0]  coef;
  logic [AccW-1:0]   acc;
  logic [AccW-lss_pkg::QShift-2:0] quot;

  // Each stage moves when the next one is empty or moving
  assign out_free    = !out_valid_q || !out_stall_i;
  assign s3_free     = !s3_valid_q || out_free;
  assign s2_free     = !s2_valid_q || s3_free;
  assign take_free_o = s2_free;

  // Center weight 1 + 4s in Q.12
  assign coef = CoefW'(lss_pkg::QOne) + CoefW'({strength_i, 2'b00});

  // Subtract, truncate toward zero, clamp to 16 bits
  assign acc  = {1'b0, prod_a_q} - AccW'(prod_b_q);
  assign quot = acc[AccW-2:lss_pkg::QShift];
  always_comb begin
    if (acc[AccW-1] || (acc == '0)) begin
      out_value_d = '0;
    end else if (quot[$bits(quot)-1:lss_pkg::PixW] != '0) begin
      out_value_d = '1;
    end else begin
      out_value_d = quot[lss_pkg::PixW-1:0];
    end
  end

  // Advance valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s2_free) begin
        s2_valid_q <= take_valid_i;
      end
      if (s3_free) begin
        s3_valid_q <= s2_valid_q;
      end
      if (out_free) begin
        out_valid_q <= s3_valid_q;
      end
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (s2_free && take_valid_i) begin
      s2_win_q <= take_win_i;
    end
    if (s3_free && s2_valid_q) begin
      prod_a_q  <= ProdAW'(coef) * ProdAW'(s2_win_q.center);
      prod_b_q  <= ProdBW'(strength_i) * ProdBW'(s2_win_q.sum4);
      s3_last_q <= s2_win_q.last;
    end
    if (out_free && s3_valid_q) begin
      out_value_q <= out_value_d;
      out_last_q  <= s3_last_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign sharp_value_o = out_value_q;
  assign frame_last_o  = out_last_q;

endmodule

// ----- rtl/laplacian_sharpen_stream.sv -----
// Top level of the five-point Laplacian sharpen stream.
// Depends on lss_pkg, lss_ram (two line stores) and lss_calc (arithmetic).
//
// Usage:
// - Pixels enter on in_valid_i / in_stall_o in row-major order; frame_start_i
//   puts a word at row 0, column 0. Frames also wrap on their own after the
//   last pixel.
// - Each pixel off the outer one-pixel ring yields one result on
//   out_valid_o / out_stall_i; the result for center (r-1, c-1) is caused by
//   input (r, c). frame_last_o marks the last result of a frame.
// - The result word passes through stage 1 (line-store read at the edge that
//   takes the input word causing it), then window and neighbor sum, two
//   products, subtract and clamp. One word is taken per cycle while
//   in_stall_o is low. The line stores are two RAMs with one read and one
//   write port each; a word reads both and writes the one of its row parity.
// - The input side keeps taking words while a result waits in the output
//   register; a long stall fills the three internal stages and then raises
//   in_stall_o.
// - Configuration (line_width, line_count, strength_q12) is to be written
//   through cfg_valid_i / cfg_ready_o only while the block is idle; the block
//   itself does not enforce this. cfg_ready_o is always high.
// - Reset clears counters, window and pipeline; line stores are not cleared,
//   and registers return to width 64, height 64, strength 0.
module laplacian_sharpen_stream #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // Pixel input
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [15:0]              pixel_value_i,
  input  logic                     frame_start_i,
  // Result output
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [15:0]              sharp_value_o,
  output logic                     frame_last_o,
  // Configuration writes
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [1:0]               cfg_index_i,
  input  logic [lss_pkg::LcW-1:0]  cfg_data_i
);

  localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = ($clog2(MAX_WIDTH + 1) > lss_pkg::LwW) ?
                      $clog2(MAX_WIDTH + 1) : lss_pkg::LwW;
  localparam int HW = lss_pkg::LcW;

  // Configuration registers
  logic [lss_pkg::LwW-1:0]  line_width_q;
  logic [lss_pkg::LcW-1:0]  line_count_q;
  logic [lss_pkg::StrW-1:0] strength_q;

  // Position counters
  logic [CW-1:0]           col_cnt_q, col_cnt_d;
  logic [lss_pkg::RowW-1:0] row_cnt_q, row_cnt_d;

  // Stage 1: word waiting for line-store data
  logic          s1_valid_q;
  lss_pkg::pix_t s1_px_q;
  logic          s1_odd_q;
  logic          s1_res_q;
  logic          s1_last_q;

  // Window: middle row at c, c-1, c-2; top row at c, c-1; previous pixel
  lss_pkg::pix_t mid0_q, mid1_q, mid2_q, top0_q, top1_q, prev_q;

  logic [WW-1:0] lw_ext, eff_w, col_ext, col_cl;
  logic [HW-1:0] eff_h, row_ext, row_cl;
  logic [CW-1:0] col_idx;
  logic          col_last, row_last, interior, pos_last;
  logic          in_accept, s1_go, take_free;
  lss_pkg::pix_t rd_even, rd_odd, top_px, mid_px;
  lss_pkg::win_t win;

  assign cfg_ready_o = 1'b1;

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= lss_pkg::LwW'(64);
      line_count_q <= lss_pkg::LcW'(64);
      strength_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (lss_pkg::cfg_idx_e'(cfg_index_i))
        lss_pkg::CFG_LINE_WIDTH: line_width_q <= cfg_data_i[lss_pkg::LwW-1:0];
        lss_pkg::CFG_LINE_COUNT: line_count_q <= cfg_data_i;
        lss_pkg::CFG_STRENGTH:   strength_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective frame size, saturated and at least one
  assign lw_ext = WW'(line_width_q);
  always_comb begin
    if (lw_ext > WW'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else if (lw_ext == '0) begin
      eff_w = WW'(1);
    end else begin
      eff_w = lw_ext;
    end
    if (line_count_q > HW'(lss_pkg::MaxRows)) begin
      eff_h = HW'(lss_pkg::MaxRows);
    end else if (line_count_q == '0) begin
      eff_h = HW'(1);
    end else begin
      eff_h = line_count_q;
    end
  end

  // Position of the incoming word, clamped to the current frame size
  assign col_ext  = frame_start_i ? '0 : WW'(col_cnt_q);
  assign row_ext  = frame_start_i ? '0 : HW'(row_cnt_q);
  assign col_cl   = (col_ext >= eff_w) ? eff_w - WW'(1) : col_ext;
  assign row_cl   = (row_ext >= eff_h) ? eff_h - HW'(1) : row_ext;
  assign col_idx  = col_cl[CW-1:0];
  assign col_last = (col_cl == eff_w - WW'(1));
  assign row_last = (row_cl == eff_h - HW'(1));
  assign interior = (col_cl >= WW'(2)) && (row_cl >= HW'(2));
  assign pos_last = col_last && row_last;

  always_comb begin
    col_cnt_d = col_cnt_q;
    row_cnt_d = row_cnt_q;
    if (col_last) begin
      col_cnt_d = '0;
      row_cnt_d = row_last ? '0 : row_cl[lss_pkg::RowW-1:0] + lss_pkg::RowW'(1);
    end else begin
      col_cnt_d = col_idx + CW'(1);
      row_cnt_d = row_cl[lss_pkg::RowW-1:0];
    end
  end

  // Handshake: stage 1 drains into the window, results go on to the math
  assign s1_go      = s1_valid_q && (!s1_res_q || take_free);
  assign in_stall_o = s1_valid_q && !s1_go;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Line stores by row parity: read both, write the current row's parity
  lss_ram #(.WIDTH(lss_pkg::PixW), .DEPTH(MAX_WIDTH)) u_ram_even (
    .clk_i   (clk_i),
    .we_i    (in_accept && !row_cl[0]),
    .waddr_i (col_idx),
    .wdata_i (pixel_value_i),
    .re_i    (in_accept),
    .raddr_i (col_idx),
    .rdata_o (rd_even)
  );

  lss_ram #(.WIDTH(lss_pkg::PixW), .DEPTH(MAX_WIDTH)) u_ram_odd (
    .clk_i   (clk_i),
    .we_i    (in_accept && row_cl[0]),
    .waddr_i (col_idx),
    .wdata_i (pixel_value_i),
    .re_i    (in_accept),
    .raddr_i (col_idx),
    .rdata_o (rd_odd)
  );

  // Same parity holds row r-2, the other row r-1
  assign top_px = s1_odd_q ? rd_odd : rd_even;
  assign mid_px = s1_odd_q ? rd_even : rd_odd;

  // Advance counters and stage 1
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q  <= '0;
      row_cnt_q  <= '0;
      s1_valid_q <= 1'b0;
      s1_res_q   <= 1'b0;
      s1_last_q  <= 1'b0;
      s1_odd_q   <= 1'b0;
    end else begin
      if (in_accept) begin
        col_cnt_q <= col_cnt_d;
        row_cnt_q <= row_cnt_d;
        s1_res_q  <= interior;
        s1_last_q <= pos_last;
        s1_odd_q  <= row_cl[0];
      end
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_go) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_px_q <= pixel_value_i;
    end
  end

  // Shift the window when stage 1 retires
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid0_q <= '0;
      mid1_q <= '0;
      mid2_q <= '0;
      top0_q <= '0;
      top1_q <= '0;
      prev_q <= '0;
    end else if (s1_go) begin
      mid0_q <= mid_px;
      mid1_q <= mid0_q;
      mid2_q <= mid1_q;
      top0_q <= top_px;
      top1_q <= top0_q;
      prev_q <= s1_px_q;
    end
  end

  // Cross neighborhood: center is the middle row one column back
  assign win.center = mid0_q;
  assign win.sum4   = lss_pkg::SumW'(top0_q) + lss_pkg::SumW'(mid1_q) +
                      lss_pkg::SumW'(mid_px) + lss_pkg::SumW'(prev_q);
  assign win.last   = s1_last_q;

  lss_calc u_calc (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .strength_i    (strength_q),
    .take_valid_i  (s1_go && s1_res_q),
    .take_win_i    (win),
    .take_free_o   (take_free),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .sharp_value_o (sharp_value_o),
    .frame_last_o  (frame_last_o)
  );

  // A word held in stage 1 keeps its pixel and its line-store data
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_go) |=> (s1_valid_q && $stable(s1_px_q) &&
                                $stable(top_px) && $stable(mid_px)))
    else $error("stage 1 word changed while held");

  // A frame start puts the next word at column 0 or 1
  a_fs_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && frame_start_i) |=> (col_cnt_q <= CW'(1)))
    else $error("column counter wrong after frame start");

  // Input is stalled only behind a word that cannot retire
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && s1_res_q && !take_free))
    else $error("input stalled without a blocked word");

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for laplacian_sharpen_stream: directed frames, then random frames.
// A predictor of the five-point sharpen checks every result word. Depends on lss_pkg.
module tb_top;

  localparam int          MaxWidth   = 2048;
  localparam int unsigned MaxGap     = 13;
  localparam int unsigned SettleCyc  = 8;
  localparam int unsigned DrainCyc   = 20;
  localparam int unsigned LongHold   = 400;
  localparam int unsigned RndTarget  = 1200;
  localparam int unsigned CycleLimit = 3000000;
  localparam logic [1:0]  CfgNoReg   = 2'd3;

  typedef struct packed {
    lss_pkg::pix_t value;
    logic          last;
  } sharp_t;

  typedef struct packed {
    logic                    is_cfg;
    logic [1:0]              idx;
    logic [lss_pkg::LcW-1:0] data;
    lss_pkg::pix_t           px;
    logic                    start;
    logic                    typed;
    lss_pkg::pix_t           exp_value;
    logic                    exp_last;
  } stim_row_t;

  // Clock, reset and block-side signals
  logic                    clk          = 1'b0;
  logic                    rst_n        = 1'b0;
  logic                    in_valid     = 1'b0;
  logic                    in_stall;
  lss_pkg::pix_t           pixel_value  = '0;
  logic                    frame_start  = 1'b0;
  logic                    out_valid;
  logic                    out_stall    = 1'b0;
  logic [15:0]             sharp_value;
  logic                    frame_last;
  logic                    cfg_valid    = 1'b0;
  logic                    cfg_ready;
  logic [1:0]              cfg_index    = '0;
  logic [lss_pkg::LcW-1:0] cfg_data     = '0;

  // Predictor state: register shadows, two line buffers, window, position
  int unsigned width_reg    = 64;
  int unsigned height_reg   = 64;
  int unsigned strength_reg = 0;
  bit [15:0]   row_mem [2*MaxWidth];
  bit [15:0]   win_q [6];
  int unsigned nxt_col      = 0;
  int unsigned nxt_row      = 0;

  sharp_t      sharp_q [$];
  stim_row_t   dir_tab [$];
  int unsigned idle_max     = MaxGap;
  int unsigned fail_cnt     = 0;
  int unsigned results_seen = 0;
  int unsigned stall_left   = 0;
  int unsigned hold_left    = 0;
  int unsigned cycle_cnt    = 0;

  laplacian_sharpen_stream DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .pixel_value_i (pixel_value),
    .frame_start_i (frame_start),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .sharp_value_o (sharp_value),
    .frame_last_o  (frame_last),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic int unsigned draw_gap();
    return (idle_max == 0) ? 0 : $urandom_range(0, idle_max);
  endfunction

  function automatic lss_pkg::pix_t pick_pixel();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return lss_pkg::pix_t'($urandom());
    endcase
  endfunction

  // Width and height as the block uses them: saturate high, zero acts as one
  function automatic int unsigned act_width();
    if (width_reg > MaxWidth) return MaxWidth;
    if (width_reg == 0) return 1;
    return width_reg;
  endfunction

  function automatic int unsigned act_height();
    if (height_reg > lss_pkg::MaxRows) return lss_pkg::MaxRows;
    if (height_reg == 0) return 1;
    return height_reg;
  endfunction

  // Advance the line buffers and window by one pixel; produce the sharpened
  // center one row up and one column left when it lies off the border ring
  task automatic predict_sharpen(input lss_pkg::pix_t px, input logic start,
                                 output bit has_res, output sharp_t res);
    int unsigned w, h, col, row, cur, prv;
    bit [15:0]   top, mid, down;
    logic [17:0] sum4;
    longint      acc;
    w = act_width();
    h = act_height();
    has_res = 1'b0;
    res = '0;
    if (start) begin
      nxt_col = 0;
      nxt_row = 0;
    end
    col = (nxt_col >= w) ? w - 1 : nxt_col;
    row = (nxt_row >= h) ? h - 1 : nxt_row;
    cur = (row % 2) * MaxWidth + col;
    prv = ((row + 1) % 2) * MaxWidth + col;
    top = row_mem[cur];
    mid = row_mem[prv];
    row_mem[cur] = px;
    win_q[2] = win_q[1];
    win_q[1] = win_q[0];
    win_q[0] = mid;
    win_q[4] = win_q[3];
    win_q[3] = top;
    down = win_q[5];
    win_q[5] = px;
    if (row >= 2 && col >= 2) begin
      sum4 = 18'(win_q[4]) + 18'(win_q[2]) + 18'(win_q[0]) + 18'(down);
      acc = (longint'(lss_pkg::QOne) + 4 * longint'(strength_reg)) *
            longint'(win_q[1]) - longint'(strength_reg) * longint'(sum4);
      if (acc <= 0) res.value = '0;
      else if (acc / lss_pkg::QOne > 65535) res.value = 16'hFFFF;
      else res.value = lss_pkg::pix_t'(acc / lss_pkg::QOne);
      res.last = (row == h - 1) && (col == w - 1);
      has_res = 1'b1;
    end
    if (col + 1 >= w) begin
      nxt_col = 0;
      nxt_row = (row + 1 >= h) ? 0 : row + 1;
    end else begin
      nxt_col = col + 1;
      nxt_row = row;
    end
  endtask

  // Offer one pixel word, hold it until taken, then queue its expected result
  task automatic send_pixel(input lss_pkg::pix_t px, input logic start,
                            input logic typed, input lss_pkg::pix_t tv,
                            input logic tl);
    int unsigned gap;
    bit          has_res;
    sharp_t      res;
    gap = draw_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    pixel_value <= px;
    frame_start <= start;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_sharpen(px, start, has_res, res);
    if (typed) begin
      res.value = tv;
      res.last  = tl;
      has_res   = 1'b1;
    end
    if (has_res) sharp_q.push_back(res);
  endtask

  // Write one register once every result is out and the pipeline has drained
  task automatic write_reg(input logic [1:0] idx,
                           input logic [lss_pkg::LcW-1:0] data);
    in_valid <= 1'b0;
    while (sharp_q.size() != 0) @(posedge clk);
    repeat (SettleCyc) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      lss_pkg::CFG_LINE_WIDTH: width_reg    = 32'(data[lss_pkg::LwW-1:0]);
      lss_pkg::CFG_LINE_COUNT: height_reg   = 32'(data);
      lss_pkg::CFG_STRENGTH:   strength_reg = 32'(data);
      default: ;
    endcase
  endtask

  // Width writes carry a random unused top bit
  task automatic set_regs(input int unsigned w, input int unsigned h,
                          input logic [lss_pkg::LcW-1:0] s);
    write_reg(lss_pkg::CFG_LINE_WIDTH, {1'($urandom_range(0, 1)), 12'(w)});
    write_reg(lss_pkg::CFG_LINE_COUNT, 13'(h));
    write_reg(lss_pkg::CFG_STRENGTH, s);
  endtask

  // Stream random pixels; optional stray frame starts break frames up
  task automatic feed_pixels(input int unsigned n, input logic first_start,
                             input bit noise);
    logic start;
    for (int unsigned k = 0; k < n; k++) begin
      if (k == 0) start = first_start;
      else start = noise && ($urandom_range(0, 79) == 0);
      send_pixel(pick_pixel(), start, 1'b0, '0, 1'b0);
    end
  endtask

  function automatic stim_row_t reg_row(input logic [1:0] idx,
                                        input logic [lss_pkg::LcW-1:0] data);
    stim_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.data   = data;
    return r;
  endfunction

  function automatic stim_row_t pix_row(input lss_pkg::pix_t px, input logic start);
    stim_row_t r;
    r = '0;
    r.px    = px;
    r.start = start;
    return r;
  endfunction

  function automatic stim_row_t chk_row(input lss_pkg::pix_t px, input lss_pkg::pix_t v,
                                        input logic l);
    stim_row_t r;
    r = '0;
    r.px        = px;
    r.typed     = 1'b1;
    r.exp_value = v;
    r.exp_last  = l;
    return r;
  endfunction

  // Result side: check each word taken, then draw the next stall
  always @(posedge clk) begin : result_side
    sharp_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (sharp_q.size() == 0) begin
          $error("unexpected result word: sharp_value %h frame_last %b",
                 sharp_value, frame_last);
          fail_cnt++;
        end else begin
          want = sharp_q.pop_front();
          if (sharp_value !== want.value) begin
            $error("sharp_value: expected %h, got %h", want.value, sharp_value);
            fail_cnt++;
          end
          if (frame_last !== want.last) begin
            $error("frame_last: expected %b, got %b", want.last, frame_last);
            fail_cnt++;
          end
        end
        results_seen++;
        stall_left = draw_gap();
        // Long hold-off lets the block fill and push back on its input
        if (results_seen == 150 || results_seen == 300) hold_left = LongHold;
      end
      out_stall <= (stall_left != 0) || (hold_left != 0);
      if (stall_left != 0) stall_left--;
      if (hold_left != 0) hold_left--;
    end
  end

  initial begin : stimulus
    int unsigned             w, h, n, part, rnd_count;
    logic [lss_pkg::LcW-1:0] s;
    wait (rst_n);
    @(posedge clk);

    // Directed: pass-through at zero strength, then clamp high and clamp low
    dir_tab.push_back(reg_row(lss_pkg::CFG_LINE_WIDTH, 13'd3));
    dir_tab.push_back(reg_row(lss_pkg::CFG_LINE_COUNT, 13'd3));
    dir_tab.push_back(reg_row(lss_pkg::CFG_STRENGTH, 13'd0));
    dir_tab.push_back(pix_row(16'h0000, 1'b1));
    dir_tab.push_back(pix_row(16'hFFFF, 1'b0));
    dir_tab.push_back(pix_row(16'h1234, 1'b0));
    dir_tab.push_back(pix_row(16'hFFFF, 1'b0));
    dir_tab.push_back(pix_row(16'hBEEF, 1'b0));
    dir_tab.push_back(pix_row(16'hFFFF, 1'b0));
    dir_tab.push_back(pix_row(16'h0001, 1'b0));
    dir_tab.push_back(pix_row(16'hFFFF, 1'b0));
    dir_tab.push_back(chk_row(16'h8000, 16'hBEEF, 1'b1));
    dir_tab.push_back(reg_row(lss_pkg::CFG_STRENGTH, 13'd4096));
    dir_tab.push_back(reg_row(lss_pkg::CFG_LINE_COUNT, 13'd4));
    dir_tab.push_back(pix_row(16'h5555, 1'b1));
    dir_tab.push_back(pix_row(16'h0000, 1'b0));
    dir_tab.push_back(pix_row(16'hAAAA, 1'b0));
    dir_tab.push_back(pix_row(16'h0000, 1'b0));
    dir_tab.push_back(pix_row(16'hFFFF, 1'b0));
    dir_tab.push_back(pix_row(16'h0000, 1'b0));
    dir_tab.push_back(pix_row(16'hFFFF, 1'b0));
    dir_tab.push_back(pix_row(16'h0000, 1'b0));
    dir_tab.push_back(chk_row(16'hFFFF, 16'hFFFF, 1'b0));
    dir_tab.push_back(pix_row(16'h7777, 1'b0));
    dir_tab.push_back(pix_row(16'hFFFF, 1'b0));
    dir_tab.push_back(chk_row(16'h0F0F, 16'h0000, 1'b1));
    // Zero width acts as one column: no interior, no results
    dir_tab.push_back(reg_row(lss_pkg::CFG_LINE_WIDTH, 13'd0));
    dir_tab.push_back(pix_row(16'hFFFF, 1'b1));
    dir_tab.push_back(pix_row(16'h0000, 1'b0));
    dir_tab.push_back(reg_row(CfgNoReg, 13'h1FFF));
    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) write_reg(dir_tab[i].idx, dir_tab[i].data);
      else send_pixel(dir_tab[i].px, dir_tab[i].start, dir_tab[i].typed,
                      dir_tab[i].exp_value, dir_tab[i].exp_last);
    end

    // Extremes: saturated width and height, rings with no interior
    set_regs(4095, 3, 13'h1FFF);
    feed_pixels(200, 1'b1, 1'b0);
    set_regs(3, 8191, 13'($urandom_range(0, 8191)));
    feed_pixels(60, 1'b1, 1'b0);
    set_regs(2, 5, 13'd100);
    feed_pixels(30, 1'b1, 1'b1);
    set_regs(7, 2, 13'd100);
    feed_pixels(30, 1'b1, 1'b1);
    set_regs(5, 0, 13'd2048);
    feed_pixels(20, 1'b1, 1'b0);

    // Random frames, some cut short by a shrink of width or height
    rnd_count = 0;
    while (rnd_count < RndTarget) begin
      idle_max = ($urandom_range(0, 3) == 0) ? 0 : MaxGap;
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(3, 12);
      h = $urandom_range(3, 8);
      case ($urandom_range(0, 5))
        0: s = '0;
        1: s = 13'(lss_pkg::QOne);
        2: s = 13'h1FFF;
        default: s = 13'($urandom_range(0, 2048));
      endcase
      if ($urandom_range(0, 7) == 0) begin
        if ($urandom_range(0, 1) == 1) w = $urandom_range(0, 2);
        else h = $urandom_range(0, 2);
        set_regs(w, h, s);
        feed_pixels($urandom_range(5, 20), 1'b1, 1'b1);
      end else begin
        n = $urandom_range(1, 3) * w * h;
        set_regs(w, h, s);
        if ($urandom_range(0, 4) == 0) begin
          part = $urandom_range(1, n - 1);
          feed_pixels(part, 1'b1, 1'b1);
          if ($urandom_range(0, 1) == 1)
            write_reg(lss_pkg::CFG_LINE_WIDTH, 13'($urandom_range(1, w)));
          else
            write_reg(lss_pkg::CFG_LINE_COUNT, 13'($urandom_range(1, h)));
          feed_pixels(n - part, 1'b0, 1'b1);
        end else begin
          feed_pixels(n, 1'b1, 1'b1);
        end
        rnd_count += n;
      end
    end

    // Drain and report
    in_valid <= 1'b0;
    while (sharp_q.size() != 0) @(posedge clk);
    repeat (DrainCyc) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
